// ===== hdl/prf_pkg.sv =====
// Package for the packet ring FIFO: operation and status codes, field widths
// and the default ring depth.
// Used by prf_mod_reduce, packet_ring_fifo_unit and prf_checker.
package prf_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int MODE_W   = 2;
  localparam int PKT_W    = 64;
  localparam int ADV_W    = 16;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 4;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam mode_t MODE_PUSH    = 2'd0;
  localparam mode_t MODE_POP     = 2'd1;
  localparam mode_t MODE_COUNT   = 2'd2;
  localparam mode_t MODE_CONSUME = 2'd3;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

endpackage

// ===== hdl/prf_mod_reduce.sv =====
// Two-stage reduction of the consume advance modulo DEPTH, by multiplying
// with a rounded-up reciprocal. Depends on prf_pkg for the advance width.
module prf_mod_reduce #(
  parameter int DEPTH = prf_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic [prf_pkg::ADV_W-1:0]    adv,
  output logic [$clog2(DEPTH)-1:0]     rem
);

  localparam int AW      = $clog2(DEPTH);
  localparam int SH      = prf_pkg::ADV_W + AW;
  localparam int RECIP_W = prf_pkg::ADV_W + 2;
  localparam int PROD_W  = prf_pkg::ADV_W + RECIP_W;
  localparam int QD_W    = prf_pkg::ADV_W + AW + 1;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SH) + longint'(DEPTH) - 64'd1) / longint'(DEPTH);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  logic [PROD_W-1:0]         prod_r;
  logic [prf_pkg::ADV_W-1:0] adv_r;
  logic [AW-1:0]             rem_r;
  logic [prf_pkg::ADV_W-1:0] quot;
  logic [QD_W-1:0]           quot_x_depth;
  logic [prf_pkg::ADV_W-1:0] rem_full;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(adv) * PROD_W'(RECIP);
    adv_r  <= adv;
  end

  // quotient is exact for every 16-bit advance, so no correction step
  always_comb begin
    quot         = prf_pkg::ADV_W'(prod_r >> SH);
    quot_x_depth = QD_W'(quot) * QD_W'(DEPTH);
    rem_full     = adv_r - prf_pkg::ADV_W'(quot_x_depth);
  end

  always_ff @(posedge clk) begin
    rem_r <= AW'(rem_full);
  end

  assign rem = rem_r;

endmodule

// ===== hdl/packet_ring_fifo_unit.sv =====
// Packet ring FIFO top level: command decode, ring pointers and packet store.
// Depends on prf_pkg and prf_mod_reduce.
//
// Usage:
//   A command word (in_mode, in_packet_in, in_advance_by) is taken at a rising
//   edge where start is high and busy is low. busy never rises, so a command
//   can be issued in every cycle.
//   Commands: push a packet, pop the oldest packet, query the fill level, or
//   consume (move the read pointer forward by in_advance_by modulo DEPTH,
//   unchecked). The ring keeps one slot free, so DEPTH-1 packets fit.
//   Every command gives one result word: out_valid is high for exactly one
//   cycle with out_status, out_packet_out and out_occupancy.
//   Throughput is one command per cycle; the stages are the reciprocal
//   multiply, the remainder, and the pointer update with the store access
//   that loads the result registers and the store read register together.
//   The receiver cannot stall: a result is lost if not taken in its cycle.
//   Reset (synchronous, rst_n low) empties the ring and drops words in
//   flight. Store contents are not cleared; the user must see that only
//   written slots are read, as the block does not enforce it.
//   out_occupancy is the fill level after the command, modulo 16.
module packet_ring_fifo_unit #(
  parameter int DEPTH = prf_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [prf_pkg::MODE_W-1:0]     in_mode,
  input  logic [prf_pkg::PKT_W-1:0]      in_packet_in,
  input  logic [prf_pkg::ADV_W-1:0]      in_advance_by,
  output logic                           out_valid,
  output logic [prf_pkg::STATUS_W-1:0]   out_status,
  output logic [prf_pkg::PKT_W-1:0]      out_packet_out,
  output logic [prf_pkg::OCC_W-1:0]      out_occupancy
);

  localparam int AW  = $clog2(DEPTH);
  localparam int FW  = AW + prf_pkg::OCC_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic [prf_pkg::PKT_W-1:0] store_mem [DEPTH];

  logic                        v1_r, v2_r, v3_r;
  prf_pkg::mode_t              mode1_r, mode2_r;
  logic [prf_pkg::PKT_W-1:0]   pkt1_r, pkt2_r;
  logic [AW-1:0]               adv_rem;

  logic [AW-1:0]               wr_r, wr_nxt;
  logic [AW-1:0]               rd_r, rd_nxt;
  logic [AW-1:0]               wr_inc, rd_inc;
  logic [AW:0]                 rd_sum;
  logic                        is_full, is_empty;
  logic                        do_push, do_pop;
  prf_pkg::status_t            status_nxt;
  logic [FW-1:0]               fill;

  prf_pkg::status_t            status_r;
  logic [prf_pkg::OCC_W-1:0]   occ_r;
  logic                        pop_ok_r;
  logic [prf_pkg::PKT_W-1:0]   rd_data_r;

  assign busy = 1'b0;

  prf_mod_reduce #(
    .DEPTH (DEPTH)
  ) u_prf_mod_reduce (
    .clk (clk),
    .adv (in_advance_by),
    .rem (adv_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    mode1_r <= in_mode;
    pkt1_r  <= in_packet_in;
    mode2_r <= mode1_r;
    pkt2_r  <= pkt1_r;
  end

  always_comb begin
    wr_inc     = (wr_r == LAST_IDX) ? '0 : wr_r + 1'b1;
    rd_inc     = (rd_r == LAST_IDX) ? '0 : rd_r + 1'b1;
    rd_sum     = (AW+1)'(rd_r) + (AW+1)'(adv_rem);
    is_full    = (wr_inc == rd_r);
    is_empty   = (wr_r == rd_r);
    do_push    = 1'b0;
    do_pop     = 1'b0;
    wr_nxt     = wr_r;
    rd_nxt     = rd_r;
    status_nxt = prf_pkg::ST_DONE;
    case (mode2_r)
      prf_pkg::MODE_PUSH: begin
        if (is_full) begin
          status_nxt = prf_pkg::ST_FULL;
        end else begin
          do_push = v2_r;
          wr_nxt  = wr_inc;
        end
      end
      prf_pkg::MODE_POP: begin
        if (is_empty) begin
          status_nxt = prf_pkg::ST_EMPTY;
        end else begin
          do_pop = v2_r;
          rd_nxt = rd_inc;
        end
      end
      prf_pkg::MODE_CONSUME: begin
        // wrap the pointer sum back into the ring
        rd_nxt = (rd_sum >= (AW+1)'(DEPTH)) ? AW'(rd_sum - (AW+1)'(DEPTH))
                                              : AW'(rd_sum);
      end
      default: begin
        status_nxt = prf_pkg::ST_DONE;
      end
    endcase
    fill = FW'(wr_nxt) - FW'(rd_nxt) + ((wr_nxt < rd_nxt) ? FW'(DEPTH) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
    end else if (v2_r) begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_mem[wr_r] <= pkt2_r;
    end
    if (do_pop) begin
      rd_data_r <= store_mem[rd_r];
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    occ_r    <= fill[prf_pkg::OCC_W-1:0];
    pop_ok_r <= do_pop;
  end

  assign out_valid      = v3_r;
  assign out_status     = status_r;
  assign out_packet_out = pop_ok_r ? rd_data_r : '0;
  assign out_occupancy  = occ_r;

endmodule

// ===== hdl/prf_checker.sv =====
// Port-level checks for packet_ring_fifo_unit: result timing and status rules.
// Depends on prf_pkg; bound to the top level at the end of this file.
module prf_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [prf_pkg::MODE_W-1:0]     in_mode,
  input  logic                           out_valid,
  input  logic [prf_pkg::STATUS_W-1:0]   out_status,
  input  logic [prf_pkg::PKT_W-1:0]      out_packet_out,
  input  logic [prf_pkg::OCC_W-1:0]      out_occupancy
);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##3 out_valid)
    else $error("command taken without a result three cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result word without a matching command");

  a_full_on_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == prf_pkg::ST_FULL |->
      $past(in_mode, 3) == prf_pkg::MODE_PUSH && out_packet_out == '0)
    else $error("full status on a command other than push");

  a_empty_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == prf_pkg::ST_EMPTY |->
      $past(in_mode, 3) == prf_pkg::MODE_POP && out_occupancy == '0
      && out_packet_out == '0)
    else $error("empty status with a nonzero fill level or wrong command");

  a_packet_only_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_packet_out != '0 |->
      $past(in_mode, 3) == prf_pkg::MODE_POP && out_status == prf_pkg::ST_DONE)
    else $error("packet data shown on a result that is not a pop");

endmodule

bind packet_ring_fifo_unit prf_checker u_prf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_mode        (in_mode),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_packet_out (out_packet_out),
  .out_occupancy  (out_occupancy)
);

// ===== tb/tb_packet_ring_fifo_unit.sv =====
// Testbench for packet_ring_fifo_unit: drives push, pop, count and consume words
// and checks every result word against a ring model kept in the bench.
// Depends on prf_pkg and the packet_ring_fifo_unit RTL.
module tb_packet_ring_fifo_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = prf_pkg::DEPTH_DEFAULT;
  localparam int PTR_W          = $clog2(DEPTH);
  localparam int RESULT_LATENCY = 3;
  localparam int STALL_LIMIT    = 500;
  localparam int RANDOM_WORDS   = 1930;

  typedef struct {
    prf_pkg::status_t            status;
    logic [prf_pkg::PKT_W-1:0]   packet;
    logic [prf_pkg::OCC_W-1:0]   occupancy;
  } ring_reply_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  logic [prf_pkg::MODE_W-1:0]     in_mode = prf_pkg::MODE_COUNT;
  logic [prf_pkg::PKT_W-1:0]      in_packet_in = '0;
  logic [prf_pkg::ADV_W-1:0]      in_advance_by = '0;
  logic                           out_valid;
  logic [prf_pkg::STATUS_W-1:0]   out_status;
  logic [prf_pkg::PKT_W-1:0]      out_packet_out;
  logic [prf_pkg::OCC_W-1:0]      out_occupancy;

  // ring model
  logic [prf_pkg::PKT_W-1:0] ring_mem [DEPTH];
  bit                        ring_written [DEPTH];
  int unsigned               wr_ptr;
  int unsigned               rd_ptr;

  ring_reply_t pending_replies [$];
  int          mismatch_count = 0;
  int          stall_cycles = 0;
  bit          no_gaps = 1'b0;

  packet_ring_fifo_unit #(.DEPTH(DEPTH)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_packet_in   (in_packet_in),
    .in_advance_by  (in_advance_by),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_packet_out (out_packet_out),
    .out_occupancy  (out_occupancy)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned ring_fill();
    return (wr_ptr + DEPTH - rd_ptr) % DEPTH;
  endfunction

  // Apply one word to the ring model and return the result it must produce.
  function automatic ring_reply_t ring_apply(prf_pkg::mode_t mode,
                                             logic [prf_pkg::PKT_W-1:0] pkt,
                                             logic [prf_pkg::ADV_W-1:0] adv);
    ring_reply_t r;
    r.status = prf_pkg::ST_DONE;
    r.packet = '0;
    case (mode)
      prf_pkg::MODE_PUSH: begin
        if ((wr_ptr + 1) % DEPTH == rd_ptr) begin
          r.status = prf_pkg::ST_FULL;
        end else begin
          ring_mem[PTR_W'(wr_ptr)] = pkt;
          ring_written[PTR_W'(wr_ptr)] = 1'b1;
          wr_ptr = (wr_ptr + 1) % DEPTH;
        end
      end
      prf_pkg::MODE_POP: begin
        if (wr_ptr == rd_ptr) begin
          r.status = prf_pkg::ST_EMPTY;
        end else begin
          r.packet = ring_mem[PTR_W'(rd_ptr)];
          rd_ptr = (rd_ptr + 1) % DEPTH;
        end
      end
      prf_pkg::MODE_CONSUME: begin
        rd_ptr = (rd_ptr + adv) % DEPTH;
      end
      default: ;
    endcase
    // occupancy wraps at 16
    r.occupancy = prf_pkg::OCC_W'(ring_fill());
    return r;
  endfunction

  // Hold the word until it is taken, then record what it must produce.
  task automatic issue_word(input prf_pkg::mode_t mode,
                            input logic [prf_pkg::PKT_W-1:0] pkt,
                            input logic [prf_pkg::ADV_W-1:0] adv);
    start         <= 1'b1;
    in_mode       <= mode;
    in_packet_in  <= pkt;
    in_advance_by <= adv;
    do @(posedge clk); while (busy);
    pending_replies.push_back(ring_apply(mode, pkt, adv));
  endtask

  task automatic sender_gap();
    if (!no_gaps && $urandom_range(0, 99) < 25) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic await_drain();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY) @(posedge clk);
  endtask

  task automatic test_empty_ring();
    issue_word(prf_pkg::MODE_POP, '0, '0);
    sender_gap();
    issue_word(prf_pkg::MODE_COUNT, '1, '1);
    sender_gap();
    issue_word(prf_pkg::MODE_CONSUME, '0, '0);
    sender_gap();
  endtask

  task automatic test_fill_and_full();
    logic [prf_pkg::PKT_W-1:0] pkt;
    for (int i = 0; i < DEPTH - 1; i++) begin
      case (i)
        0:       pkt = '0;
        1:       pkt = '1;
        2:       pkt = 64'hAAAA_AAAA_AAAA_AAAA;
        3:       pkt = 64'h5555_5555_5555_5555;
        4:       pkt = 64'h0706_0504_0302_0100;
        5:       pkt = 64'h8000_0000_0000_0001;
        default: pkt = {$urandom, $urandom};
      endcase
      issue_word(prf_pkg::MODE_PUSH, pkt, '0);
      sender_gap();
    end
    // ring holds DEPTH-1 now: this push must be refused
    issue_word(prf_pkg::MODE_PUSH, 64'hDEAD_BEEF_0BAD_F00D, '0);
    sender_gap();
    issue_word(prf_pkg::MODE_COUNT, '0, '0);
    sender_gap();
  endtask

  task automatic test_wrap_consume();
    issue_word(prf_pkg::MODE_CONSUME, '0, 16'd16);
    sender_gap();
    issue_word(prf_pkg::MODE_POP, '0, '0);
    sender_gap();
    // wraps the read pointer back behind the write pointer
    issue_word(prf_pkg::MODE_CONSUME, '0, 16'hFFFF);
    sender_gap();
    issue_word(prf_pkg::MODE_POP, '0, '0);
    sender_gap();
  endtask

  task automatic test_random_traffic();
    prf_pkg::mode_t            mode;
    logic [prf_pkg::ADV_W-1:0] adv;
    int                        pick;
    bit                        fill_phase;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      no_gaps    = (i >= 600 && i < 1000);
      fill_phase = ((i / 64) % 2 == 0);
      if (i == 1300) await_drain();
      pick = $urandom_range(0, 99);
      if (fill_phase) begin
        mode = (pick < 55) ? prf_pkg::MODE_PUSH : (pick < 85) ? prf_pkg::MODE_POP :
               (pick < 92) ? prf_pkg::MODE_COUNT : prf_pkg::MODE_CONSUME;
      end else begin
        mode = (pick < 25) ? prf_pkg::MODE_PUSH : (pick < 75) ? prf_pkg::MODE_POP :
               (pick < 85) ? prf_pkg::MODE_COUNT : prf_pkg::MODE_CONSUME;
      end
      if ($urandom_range(0, 3) == 0)
        adv = prf_pkg::ADV_W'($urandom_range(0, 65535));
      else
        adv = prf_pkg::ADV_W'($urandom_range(0, ring_fill()));
      // never pop a slot that was not written since reset
      if (mode == prf_pkg::MODE_POP && wr_ptr != rd_ptr && !ring_written[PTR_W'(rd_ptr)])
        mode = prf_pkg::MODE_PUSH;
      issue_word(mode, {$urandom, $urandom}, adv);
      sender_gap();
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk) begin
    ring_reply_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        $error("result word with nothing expected");
        mismatch_count++;
      end else begin
        exp_r = pending_replies.pop_front();
        if (out_status !== exp_r.status) begin
          $error("out_status: expected %0d, actual %0d", exp_r.status, out_status);
          mismatch_count++;
        end
        if (out_packet_out !== exp_r.packet) begin
          $error("out_packet_out: expected %h, actual %h", exp_r.packet, out_packet_out);
          mismatch_count++;
        end
        if (out_occupancy !== exp_r.occupancy) begin
          $error("out_occupancy: expected %0d, actual %0d", exp_r.occupancy,
                 out_occupancy);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("packet_ring_fifo_unit verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wr_ptr = 0;
    rd_ptr = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_ring();
    test_fill_and_full();
    test_wrap_consume();
    await_drain();
    test_random_traffic();
    await_drain();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("packet_ring_fifo_unit verification clean");
    end else begin
      $display("packet_ring_fifo_unit verification failed");
    end
    $finish;
  end

endmodule
